/* sv/tdes_cbc_mac_engine_defines.svh */
// Assertion macros used by the checker file
`ifndef TDES_CBC_MAC_ENGINE_DEFINES_SVH
`define TDES_CBC_MAC_ENGINE_DEFINES_SVH
// Assert an implication on every clock edge outside reset
`define TCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcm check failed");
// Assert an implication in the next cycle
`define TCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcm check failed");
`endif

/* sv/tcm_pkg.sv */
// Package: DES tables, helper functions and controller types
`default_nettype none
package tcm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_PASS,
        ST_OUT
    } tcm_state_t;

    localparam logic [1:0] REG_KEY_ONE = 2'd0;
    localparam logic [1:0] REG_KEY_TWO = 2'd1;
    localparam logic [1:0] REG_IV      = 2'd2;
    localparam logic [1:0] REG_MODE    = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;       // capture input word, run IP, set pass key
        logic       round;      // execute one Feistel round
        logic       pass_next;  // finish pass, start next pass
        logic [1:0] pass_sel;   // pass index for the next pass
        logic       finish;     // finish last pass and latch chain/mac
        logic       last;       // current word is last of message
    } tcm_cmd_t;

    function automatic logic [3:0] sbox(input logic [2:0] n, input logic [5:0] six);
        logic [1:0] row;
        logic [3:0] col;
        logic [255:0] t0, t1, t2, t3, t4, t5, t6, t7;
        logic [255:0] sel;
        row = {six[5], six[0]};
        col = six[4:1];
        t0 = 256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D;
        t1 = 256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9;
        t2 = 256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C;
        t3 = 256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E;
        t4 = 256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453;
        t5 = 256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D;
        t6 = 256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C;
        t7 = 256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B;
        case (n)
            3'd0: sel = t0;
            3'd1: sel = t1;
            3'd2: sel = t2;
            3'd3: sel = t3;
            3'd4: sel = t4;
            3'd5: sel = t5;
            3'd6: sel = t6;
            default: sel = t7;
        endcase
        return sel[255 - ({row, col} * 4) -: 4];
    endfunction

    // Generic MSB-first permutation helpers are written out per table below
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [7:0] t [0:63];
        logic [63:0] o;
        t = '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
              62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
              57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
              61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
        for (int i = 0; i < 64; i++) o[63-i] = x[64 - t[i]];
        return o;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [7:0] t [0:63];
        logic [63:0] o;
        t = '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
              38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
              36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
              34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
        for (int i = 0; i < 64; i++) o[63-i] = x[64 - t[i]];
        return o;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [7:0] t [0:55];
        logic [55:0] o;
        t = '{57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
              10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
              63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
              14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
        for (int i = 0; i < 56; i++) o[55-i] = x[64 - t[i]];
        return o;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [7:0] t [0:47];
        logic [47:0] o;
        t = '{14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
              41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
              46,42,50,36,29,32};
        for (int i = 0; i < 48; i++) o[47-i] = x[56 - t[i]];
        return o;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [7:0] te [0:47];
        logic [7:0] tp [0:31];
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] o;
        te = '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
               16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
               28,29,30,31,32,1};
        tp = '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
               2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
        for (int i = 0; i < 48; i++) e[47-i] = r[32 - te[i]];
        e = e ^ k;
        for (int i = 0; i < 8; i++)
            s[31-4*i -: 4] = sbox(3'(i), e[47-6*i -: 6]);
        for (int i = 0; i < 32; i++) o[31-i] = s[32 - tp[i]];
        return o;
    endfunction

    // Rotate both 28-bit halves left by the given amount
    function automatic logic [55:0] rot_cd(input logic [55:0] cd, input logic two);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        if (two) return {c[25:0], c[27:26], d[25:0], d[27:26]};
        return {c[26:0], c[27], d[26:0], d[27]};
    endfunction

    function automatic logic [55:0] rotr_cd(input logic [55:0] cd, input logic two);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        if (two) return {c[1:0], c[27:2], d[1:0], d[27:2]};
        return {c[0], c[27:1], d[0], d[27:1]};
    endfunction

    // Shift amount per round: one for rounds 0, 1, 8, 15
    function automatic logic rot_two(input logic [3:0] rnd);
        return !(rnd == 4'd0 || rnd == 4'd1 || rnd == 4'd8 || rnd == 4'd15);
    endfunction

endpackage
`default_nettype wire

/* sv/tcm_ctrl.sv */
// Controller: sequences passes and rounds of the DES core
`default_nettype none
module tcm_ctrl
    import tcm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_last,
    input  wire logic     mode,
    input  wire logic     out_stall,
    output logic          in_stall,
    output logic          out_valid,
    output tcm_cmd_t      cmd
);

    tcm_state_t state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic [1:0] pass_reg, pass_next;
    logic       last_reg, last_next;
    logic       triple;

    assign triple = mode || last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        pass_next  = pass_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = 4'd0;
                    pass_next  = 2'd0;
                    last_next  = in_last;
                end
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd15)
                begin
                    if (triple && pass_reg != 2'd2)
                        pass_next = pass_reg + 2'd1;
                    else if (last_reg)
                        state_next = ST_OUT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.last  = last_reg;
        cmd.pass_sel = pass_reg + 2'd1;
        if (state_reg == ST_ROUND)
        begin
            cmd.round = 1'b1;
            if (rnd_reg == 4'd15)
            begin
                if (triple && pass_reg != 2'd2)
                    cmd.pass_next = 1'b1;
                else
                    cmd.finish = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            pass_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            pass_reg  <= pass_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

/* sv/tcm_datapath.sv */
// Datapath: chaining, one DES round per cycle, key schedule, result register
`default_nettype none
module tcm_datapath
    import tcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tcm_cmd_t    cmd,
    input  wire logic [63:0] key_one,
    input  wire logic [63:0] key_two,
    input  wire logic [63:0] init_vector,
    input  wire logic        mode,
    input  wire logic [63:0] block_data,
    input  wire logic [3:0]  block_bytes,
    output logic      [63:0] mac_value
);

    logic [63:0] chain_reg;
    logic        in_msg_reg;
    logic [63:0] cv_reg;
    logic [31:0] l_reg, r_reg;
    logic [55:0] cd_reg;
    logic        dec_reg;
    logic [3:0]  rnd_reg;
    logic [63:0] mac_reg;

    logic [63:0] mask, x, cv, blk_out;
    logic [55:0] cd_use, cd_after;
    logic [31:0] r_new;
    logic [63:0] pass_out;
    logic [55:0] k1_cd, k2_cd;

    assign k1_cd = perm_pc1(key_one);
    assign k2_cd = perm_pc1(key_two);

    // Zero bytes beyond the count
    always_comb
    begin
        mask = '1;
        if (block_bytes == 4'd0)
            mask = '0;
        else if (block_bytes < 4'd8)
            mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> (block_bytes[2:0] * 8));
        cv = in_msg_reg ? chain_reg : init_vector;
        x  = (block_data & mask) ^ cv;
    end

    // One round: encrypt rotates before use, decrypt uses then rotates right
    always_comb
    begin
        cd_use   = dec_reg ? cd_reg : rot_cd(cd_reg, rot_two(rnd_reg));
        cd_after = dec_reg ? rotr_cd(cd_reg, rot_two(4'd15 - rnd_reg)) : cd_use;
        r_new    = l_reg ^ feistel(r_reg, perm_pc2(cd_use));
        pass_out = perm_fp({r_new, r_reg});
        blk_out  = mode ? pass_out : {cv_reg[63:32], pass_out[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg  <= '0;
            in_msg_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            chain_reg  <= pass_out;
            in_msg_reg <= !cmd.last;
        end
    end

    // Advance the block state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cv_reg  <= cv;
            {l_reg, r_reg} <= perm_ip(x);
            cd_reg  <= k1_cd;
            dec_reg <= 1'b0;
            rnd_reg <= 4'd0;
        end
        else if (cmd.pass_next)
        begin
            {l_reg, r_reg} <= perm_ip(pass_out);
            cd_reg  <= (cmd.pass_sel == 2'd1) ? k2_cd : k1_cd;
            dec_reg <= (cmd.pass_sel == 2'd1);
            rnd_reg <= 4'd0;
        end
        else if (cmd.round)
        begin
            l_reg   <= r_reg;
            r_reg   <= r_new;
            cd_reg  <= cd_after;
            rnd_reg <= rnd_reg + 4'd1;
        end
        if (cmd.finish && cmd.last)
            mac_reg <= blk_out;
    end

    assign mac_value = mac_reg;

endmodule
`default_nettype wire

/* sv/tdes_cbc_mac_engine.sv */
// Top level: two-key triple DES retail / full CBC-MAC engine
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | block_data, block_bytes, last_block
//  out      | out_valid/out_stall| mac_value, mac_tail_word
//  config   | cfg_we             | cfg_index, cfg_data
// One DES round per cycle from a single round unit: a word takes one pass
// (retail, not last) or three passes (triple DES), after a load while idle.
// A last word then presents the result word.
// The result word is held until taken; no new word enters meanwhile.
// Reset clears chain value, message flag, config and controller state.
`default_nettype none
module tdes_cbc_mac_engine
    import tcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] block_data,
    input  wire logic [3:0]  block_bytes,
    input  wire logic        last_block,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] mac_value,
    output logic      [31:0] mac_tail_word
);

    logic [63:0] key_one_reg, key_two_reg, iv_reg;
    logic        mode_reg;
    tcm_cmd_t    cmd;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_one_reg <= '0;
            key_two_reg <= '0;
            iv_reg      <= '0;
            mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_ONE: key_one_reg <= cfg_data;
                REG_KEY_TWO: key_two_reg <= cfg_data;
                REG_IV:      iv_reg      <= cfg_data;
                REG_MODE:    mode_reg    <= cfg_data[0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    tcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last_block),
        .mode      (mode_reg),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    tcm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key_one     (key_one_reg),
        .key_two     (key_two_reg),
        .init_vector (iv_reg),
        .mode        (mode_reg),
        .block_data  (block_data),
        .block_bytes (block_bytes),
        .mac_value   (mac_value)
    );

    assign mac_tail_word = mac_value[31:0];

endmodule
`default_nettype wire

/* sv/tcm_checker.sv */
// Port-level checker for the MAC engine, bound to the top level
`default_nettype none
`include "tdes_cbc_mac_engine_defines.svh"
module tcm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] mac_value,
    input wire logic [31:0] mac_tail_word
);
    // Tail word mirrors the low half of the MAC
    `TCM_ASSERT_IMP(a_tail, clk, rst_n, out_valid, mac_tail_word == mac_value[31:0])
    // No word is taken while a result waits
    `TCM_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall)
    // A waiting result holds
    `TCM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(mac_value))
    // An accepted word blocks the input on the next cycle
    `TCM_ASSERT_NEXT(a_take, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind tdes_cbc_mac_engine tcm_checker u_tcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mac_value     (mac_value),
    .mac_tail_word (mac_tail_word)
);
`default_nettype wire
